@@ hdl/ufmms_pkg.sv @@
// Package for the disjoint-set store: widths, constants, state and queue types.
// Depends on nothing; every other file but ufmms_if imports it.
package ufmms_pkg;

   localparam int NUM_ELEMENTS = 1024;
   localparam int ELEM_W       = 11;
   localparam int ADDR_W       = $clog2(NUM_ELEMENTS);
   localparam int QUEUE_DEPTH  = 2;

   typedef logic [ELEM_W-1:0] elem_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic {
      OP_UNION = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Request transaction as seen on the input channel
   typedef struct packed {
      op_type   operation;
      elem_type elem_a;
      elem_type elem_b;
   } req_type;

   // One classified command passed from front to back
   typedef struct packed {
      op_type   op;
      logic     valid_a;
      logic     valid_b;
      elem_type elem_a;
      elem_type elem_b;
   } cmd_type;

   typedef struct packed {
      elem_type set_min;
      elem_type set_max;
      elem_type set_size;
      logic     in_range;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_WT,
      ST_COMP_RD,
      ST_COMP_WT,
      ST_NEXT,
      ST_INFO_RD,
      ST_INFO_WT,
      ST_MERGE,
      ST_RESP
   } state_type;

   // Map an element number (1..NUM_ELEMENTS) to a memory address
   function automatic addr_type to_addr(elem_type e);
      elem_type d;
      d = e - elem_type'(1);
      return d[ADDR_W-1:0];
   endfunction

   function automatic elem_type to_elem(addr_type a);
      return elem_type'(a) + elem_type'(1);
   endfunction

endpackage

@@ hdl/ufmms_if.sv @@
// Valid/ready channel interface carrying a typed payload.
// Depends on nothing.
interface ufmms_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/ufmms_front.sv @@
// Front end: accept requests, range check elements, push into a short queue.
// Depends on ufmms_pkg.
module ufmms_front
   import ufmms_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  elem_type  limit,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic      req_operation,
   input  elem_type  req_elem_a,
   input  elem_type  req_elem_b,
   output logic      cmd_valid,
   input  logic      cmd_ready,
   output cmd_type   cmd_data
);

   cmd_type     q_ff [QUEUE_DEPTH];
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   cmd_type     cmd_new;
   logic        push, pop;

   // Classify the incoming transaction
   always_comb begin
      cmd_new.op      = op_type'(req_operation);
      cmd_new.elem_a  = req_elem_a;
      cmd_new.elem_b  = req_elem_b;
      cmd_new.valid_a = (req_elem_a != '0) && (req_elem_a <= limit);
      cmd_new.valid_b = (req_elem_b != '0) && (req_elem_b <= limit);
   end

   assign req_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   // Advance queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cmd_new;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(QUEUE_DEPTH) |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

@@ hdl/ufmms_back.sv @@
// Back end: root finding with path compression, union by size, query replies.
// Depends on ufmms_pkg. Holds the four element memories.
module ufmms_back
   import ufmms_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     cmd_valid,
   output logic     cmd_ready,
   input  cmd_type  cmd_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   // Memories, one entry per element
   elem_type par_mem [NUM_ELEMENTS];
   elem_type cnt_mem [NUM_ELEMENTS];
   elem_type low_mem [NUM_ELEMENTS];
   elem_type hig_mem [NUM_ELEMENTS];

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic      side_ff, side_in;     // 0: elem_a, 1: elem_b
   addr_type  cur_ff, cur_in;
   addr_type  root_ff, root_in;
   addr_type  ra_ff, ra_in;
   addr_type  clr_ff, clr_in;
   logic      info_ff, info_in;     // which root's info is being read
   elem_type  sa_ff, sa_in, la_ff, la_in, ha_ff, ha_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rv_ff, rv_in;

   // Memory port control
   addr_type  rd_addr;
   logic      rd_en;
   elem_type  par_q, cnt_q, low_q, hig_q;
   logic      par_we, inf_we;
   addr_type  par_wa, inf_wa;
   elem_type  par_wd, cnt_wd, low_wd, hig_wd;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         par_q <= par_mem[rd_addr];
         cnt_q <= cnt_mem[rd_addr];
         low_q <= low_mem[rd_addr];
         hig_q <= hig_mem[rd_addr];
      end
      if (par_we) par_mem[par_wa] <= par_wd;
      if (inf_we) begin
         cnt_mem[inf_wa] <= cnt_wd;
         low_mem[inf_wa] <= low_wd;
         hig_mem[inf_wa] <= hig_wd;
      end
   end

   assign cmd_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // Next state, memory control and datapath
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      side_in  = side_ff;
      cur_in   = cur_ff;
      root_in  = root_ff;
      ra_in    = ra_ff;
      clr_in   = clr_ff;
      info_in  = info_ff;
      sa_in    = sa_ff;
      la_in    = la_ff;
      ha_in    = ha_ff;
      rsp_in   = rsp_ff;
      rv_in    = rv_ff && !rsp_ready;
      rd_en    = 1'b0;
      rd_addr  = cur_ff;
      par_we   = 1'b0;
      par_wa   = cur_ff;
      par_wd   = to_elem(root_ff);
      inf_we   = 1'b0;
      inf_wa   = clr_ff;
      cnt_wd   = elem_type'(1);
      low_wd   = to_elem(clr_ff);
      hig_wd   = to_elem(clr_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep every entry back to a singleton
            par_we = 1'b1;
            par_wa = clr_ff;
            par_wd = to_elem(clr_ff);
            inf_we = 1'b1;
            clr_in = clr_ff + addr_type'(1);
            if (clr_ff == addr_type'(NUM_ELEMENTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid && !rv_ff) begin
               cmd_in  = cmd_data;
               side_in = 1'b0;
               cur_in  = to_addr(cmd_data.elem_a);
               if (cmd_data.op == OP_QUERY && !cmd_data.valid_a) begin
                  rsp_in   = '0;
                  state_in = ST_RESP;
               end else if (cmd_data.op == OP_UNION &&
                            !(cmd_data.valid_a && cmd_data.valid_b)) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FIND_RD;
               end
            end
         end
         ST_FIND_RD: begin
            rd_en    = 1'b1;
            state_in = ST_FIND_WT;
         end
         ST_FIND_WT: begin
            // Follow the link until an entry points at itself
            if (par_q == to_elem(cur_ff)) begin
               root_in  = cur_ff;
               cur_in   = side_ff ? to_addr(cmd_ff.elem_b) : to_addr(cmd_ff.elem_a);
               state_in = ST_COMP_RD;
            end else begin
               cur_in   = to_addr(par_q);
               state_in = ST_FIND_RD;
            end
         end
         ST_COMP_RD: begin
            if (cur_ff == root_ff) begin
               state_in = ST_NEXT;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_COMP_WT;
            end
         end
         ST_COMP_WT: begin
            // Point this entry straight at the root and step on
            par_we   = 1'b1;
            cur_in   = to_addr(par_q);
            state_in = ST_COMP_RD;
         end
         ST_NEXT: begin
            if (cmd_ff.op == OP_QUERY) begin
               cur_in   = root_ff;
               state_in = ST_INFO_RD;
            end else if (!side_ff) begin
               ra_in    = root_ff;
               side_in  = 1'b1;
               cur_in   = to_addr(cmd_ff.elem_b);
               state_in = ST_FIND_RD;
            end else if (ra_ff == root_ff) begin
               state_in = ST_IDLE;
            end else begin
               info_in  = 1'b0;
               cur_in   = ra_ff;
               state_in = ST_INFO_RD;
            end
         end
         ST_INFO_RD: begin
            rd_en    = 1'b1;
            state_in = ST_INFO_WT;
         end
         ST_INFO_WT: begin
            if (cmd_ff.op == OP_QUERY) begin
               rsp_in.set_min  = low_q;
               rsp_in.set_max  = hig_q;
               rsp_in.set_size = cnt_q;
               rsp_in.in_range = 1'b1;
               state_in        = ST_RESP;
            end else if (!info_ff) begin
               sa_in    = cnt_q;
               la_in    = low_q;
               ha_in    = hig_q;
               info_in  = 1'b1;
               cur_in   = root_ff;
               state_in = ST_INFO_RD;
            end else begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            // Smaller root goes under the larger; a tie keeps the second root
            inf_we = 1'b1;
            par_we = 1'b1;
            cnt_wd = sa_ff + cnt_q;
            low_wd = (la_ff < low_q) ? la_ff : low_q;
            hig_wd = (ha_ff > hig_q) ? ha_ff : hig_q;
            if (sa_ff > cnt_q) begin
               par_wa = root_ff;
               par_wd = to_elem(ra_ff);
               inf_wa = ra_ff;
            end else begin
               par_wa = ra_ff;
               par_wd = to_elem(root_ff);
               inf_wa = root_ff;
            end
            state_in = ST_IDLE;
         end
         ST_RESP: begin
            rv_in    = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      side_ff <= side_in;
      cur_ff  <= cur_in;
      root_ff <= root_in;
      ra_ff   <= ra_in;
      info_ff <= info_in;
      sa_ff   <= sa_in;
      la_ff   <= la_in;
      ha_ff   <= ha_in;
      rsp_ff  <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff && $stable(rsp_ff)) else $error("response dropped");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> state_ff == ST_IDLE) else $error("command taken while busy");
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP |-> !rv_ff) else $error("response overwritten");
`endif

endmodule

@@ hdl/union_find_min_max_size.sv @@
// Top level of the disjoint-set store with set min, max and size.
// Depends on ufmms_pkg, ufmms_if, ufmms_front and ufmms_back.
//
//   channel  dir  payload
//   req      in   operation, elem_a, elem_b
//   rsp      out  set_min, set_max, set_size, in_range
//   csr      in   element_count write
//
// After reset a clearing pass over every entry initialises the memories; no
// request is taken by the back end during it. A query walks the links from
// the element to its root and compresses that path; an out-of-range query is
// answered without a walk and an ignored union is dropped. A union walks both
// paths and skips the merge when both roots match. The single read port of
// the element memories sets the pace. A two-entry queue decouples request
// intake from the back end.
module union_find_min_max_size
   import ufmms_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ufmms_if.sink     req,
   ufmms_if.source   rsp,
   input  logic      csr_we,
   input  elem_type  csr_wdata
);

   elem_type limit_ff, limit_in;
   elem_type limit;
   logic     cmd_valid, cmd_ready;
   cmd_type  cmd_data;
   rsp_type  rsp_data;

   always_comb limit_in = csr_we ? csr_wdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= elem_type'(NUM_ELEMENTS);
      else       limit_ff <= limit_in;
   end

   // Clamp the bound to the store size
   assign limit = (limit_ff > elem_type'(NUM_ELEMENTS)) ? elem_type'(NUM_ELEMENTS)
                                                         : limit_ff;

   ufmms_front u_front (
      .clock         (clock),
      .reset         (reset),
      .limit         (limit),
      .req_valid     (req.valid),
      .req_ready     (req.ready),
      .req_operation (req.data.operation),
      .req_elem_a    (req.data.elem_a),
      .req_elem_b    (req.data.elem_b),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd_data      (cmd_data)
   );

   ufmms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp.data.set_min  = rsp_data.set_min;
   assign rsp.data.set_max  = rsp_data.set_max;
   assign rsp.data.set_size = rsp_data.set_size;
   assign rsp.data.in_range = rsp_data.in_range;

endmodule

@@ bench/ufmms_tb_if.sv @@
`timescale 1ns / 100ps
// Helper for building request transactions in the testbench.
// Depends on ufmms_pkg.
package ufmms_tb_pkg;
   import ufmms_pkg::*;

   function automatic req_type make_req(op_type op, int unsigned a, int unsigned b);
      req_type t;
      t.operation = op;
      t.elem_a    = elem_type'(a);
      t.elem_b    = elem_type'(b);
      return t;
   endfunction
endpackage

@@ bench/union_find_min_max_size_tb.sv @@
`timescale 1ns / 100ps
// Testbench for union_find_min_max_size: random and directed union/query traffic
// checked against a behavioural disjoint-set predictor. Depends on ufmms_pkg,
// ufmms_if, ufmms_tb_pkg and the RTL.
module union_find_min_max_size_tb;
   import ufmms_pkg::*;
   import ufmms_tb_pkg::*;

   localparam int STALL_LIMIT = 200000;

   logic clock;
   logic reset;
   logic csr_we;
   elem_type csr_wdata;

   ufmms_if #(.payload_type(req_type)) req ();
   ufmms_if #(.payload_type(rsp_type)) rsp ();

   union_find_min_max_size dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predictor state, indexed by element number
   int unsigned link_tbl[NUM_ELEMENTS+1];
   int unsigned size_tbl[NUM_ELEMENTS+1];
   int unsigned low_tbl[NUM_ELEMENTS+1];
   int unsigned high_tbl[NUM_ELEMENTS+1];
   int unsigned elem_limit;

   req_type pending_reqs[$];
   rsp_type expected_sets[$];
   int errors = 0;
   int queries_seen = 0;
   int unions_sent = 0;
   bit quiet_phase = 0;
   bit stim_done = 0;
   bit in_taken = 0;
   int drv_gap = 0;
   int snk_gap = 0;
   int idle_cycles = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic bit elem_ok(int unsigned e);
      int unsigned lim;
      lim = (elem_limit > NUM_ELEMENTS) ? NUM_ELEMENTS : elem_limit;
      return e >= 1 && e <= lim;
   endfunction

   // walk to the root, then point every node on the path straight at it
   function automatic int unsigned find_root(int unsigned e);
      int unsigned r;
      int unsigned nxt;
      r = e;
      while (link_tbl[r] != r) r = link_tbl[r];
      while (e != r) begin
         nxt = link_tbl[e];
         link_tbl[e] = r;
         e = nxt;
      end
      return r;
   endfunction

   // apply one transaction to the predictor and queue any expected result
   function automatic void predict_sets(req_type t);
      int unsigned ra, rb, keep, drop;
      rsp_type r;
      if (t.operation == OP_UNION) begin
         if (!elem_ok(t.elem_a) || !elem_ok(t.elem_b)) return;
         ra = find_root(t.elem_a);
         rb = find_root(t.elem_b);
         if (ra == rb) return;
         if (size_tbl[ra] > size_tbl[rb]) begin
            keep = ra; drop = rb;
         end else begin
            keep = rb; drop = ra;
         end
         link_tbl[drop] = keep;
         size_tbl[keep] += size_tbl[drop];
         if (high_tbl[drop] > high_tbl[keep]) high_tbl[keep] = high_tbl[drop];
         if (low_tbl[drop] < low_tbl[keep]) low_tbl[keep] = low_tbl[drop];
         return;
      end
      r = '0;
      if (elem_ok(t.elem_a)) begin
         ra = find_root(t.elem_a);
         r.set_min  = elem_type'(low_tbl[ra]);
         r.set_max  = elem_type'(high_tbl[ra]);
         r.set_size = elem_type'(size_tbl[ra]);
         r.in_range = 1'b1;
      end
      expected_sets.push_back(r);
   endfunction

   // driver: present pending transactions with random gaps outside the quiet phase
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && !in_taken) begin
         // hold until accepted
      end else if (drv_gap > 0) begin
         drv_gap <= drv_gap - 1;
         req.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         req.data  <= pending_reqs.pop_front();
         req.valid <= 1'b1;
         if (!quiet_phase && $urandom_range(0, 5) == 0) drv_gap <= $urandom_range(1, 7);
      end else begin
         req.valid <= 1'b0;
      end
   end

   // response back-pressure in bursts, off in the quiet phase
   always @(negedge clock) begin
      if (reset || quiet_phase) begin
         rsp.ready <= 1'b1;
      end else if (snk_gap > 0) begin
         snk_gap <= snk_gap - 1;
         rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         snk_gap <= $urandom_range(0, 6);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // monitor: predict on request acceptance, compare on response acceptance
   always @(posedge clock) begin
      rsp_type exp_r;
      bit      seen;
      seen = 1'b0;
      in_taken <= !reset && req.valid && req.ready;
      if (!reset) begin
         if (req.valid && req.ready) begin
            predict_sets(req.data);
            if (req.data.operation == OP_UNION) unions_sent <= unions_sent + 1;
            seen = 1'b1;
         end
         if (rsp.valid && rsp.ready) begin
            seen = 1'b1;
            queries_seen <= queries_seen + 1;
            if (expected_sets.size() == 0) begin
               $error("unexpected response %p", rsp.data);
               errors = errors + 1;
            end else begin
               exp_r = expected_sets.pop_front();
               if (rsp.data.set_min !== exp_r.set_min) begin
                  $error("set_min expected %0d got %0d", exp_r.set_min, rsp.data.set_min);
                  errors = errors + 1;
               end
               if (rsp.data.set_max !== exp_r.set_max) begin
                  $error("set_max expected %0d got %0d", exp_r.set_max, rsp.data.set_max);
                  errors = errors + 1;
               end
               if (rsp.data.set_size !== exp_r.set_size) begin
                  $error("set_size expected %0d got %0d", exp_r.set_size,
                         rsp.data.set_size);
                  errors = errors + 1;
               end
               if (rsp.data.in_range !== exp_r.in_range) begin
                  $error("in_range expected %0d got %0d", exp_r.in_range,
                         rsp.data.in_range);
                  errors = errors + 1;
               end
            end
         end
         idle_cycles <= seen ? 0 : idle_cycles + 1;
      end
   end

   // watchdog: covers the clearing pass and the longest union walks
   always @(posedge clock) begin
      if (idle_cycles > STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // wait for the block to drain, then for a settle margin
   task automatic drain_block();
      while (pending_reqs.size() > 0 || req.valid || expected_sets.size() > 0)
         @(posedge clock);
      repeat (4000) @(posedge clock);
   endtask

   task automatic write_count(int unsigned n);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= elem_type'(n);
      elem_limit = n;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly in-range elements, sometimes the edges or junk
   function automatic int unsigned pick_elem(int unsigned span);
      case ($urandom_range(0, 19))
         0: return 0;
         1: return $urandom_range(0, 2047);
         2: return span;
         3: return span + 1;
         default: return $urandom_range(1, span);
      endcase
   endfunction

   task automatic random_phase(int unsigned count, int unsigned span);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 2) == 0)
            pending_reqs.push_back(make_req(OP_QUERY, pick_elem(span),
                                            $urandom_range(0, 2047)));
         else
            pending_reqs.push_back(make_req(OP_UNION, pick_elem(span), pick_elem(span)));
      end
      drain_block();
   endtask

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      elem_limit = 1024;
      for (int i = 0; i <= NUM_ELEMENTS; i++) begin
         link_tbl[i] = i; size_tbl[i] = 1; low_tbl[i] = i; high_tbl[i] = i;
      end
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: edges, tie linking, out-of-range and redundant unions
      pending_reqs.push_back(make_req(OP_QUERY, 1, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 1024, 2047));
      pending_reqs.push_back(make_req(OP_QUERY, 0, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 1025, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 2047, 0));
      pending_reqs.push_back(make_req(OP_UNION, 1, 1024));
      pending_reqs.push_back(make_req(OP_QUERY, 1, 0));
      pending_reqs.push_back(make_req(OP_UNION, 500, 3));
      pending_reqs.push_back(make_req(OP_UNION, 3, 1024));
      pending_reqs.push_back(make_req(OP_UNION, 1024, 1));
      pending_reqs.push_back(make_req(OP_UNION, 0, 5));
      pending_reqs.push_back(make_req(OP_UNION, 5, 2047));
      pending_reqs.push_back(make_req(OP_QUERY, 500, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 5, 0));
      drain_block();

      // shrink the range below existing members, then widen past the store
      write_count(1);
      pending_reqs.push_back(make_req(OP_QUERY, 1, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 2, 0));
      pending_reqs.push_back(make_req(OP_UNION, 1, 2));
      pending_reqs.push_back(make_req(OP_UNION, 1, 1));
      drain_block();
      write_count(2047);
      pending_reqs.push_back(make_req(OP_QUERY, 1024, 0));
      pending_reqs.push_back(make_req(OP_QUERY, 1025, 0));
      drain_block();

      // random traffic over several ranges
      write_count(16);
      random_phase(400, 16);
      write_count(100);
      random_phase(500, 100);
      write_count(1024);
      random_phase(450, 1024);
      write_count(40);
      quiet_phase = 1;
      random_phase(400, 40);

      $display("covered %0d unions and %0d query responses over range settings",
               unions_sent, queries_seen);
      $display("element_count 1, 16, 40, 100, 1024 and 2047 exercised");
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

@@ files.f @@
hdl/ufmms_pkg.sv
hdl/ufmms_if.sv
hdl/ufmms_front.sv
hdl/ufmms_back.sv
hdl/union_find_min_max_size.sv
bench/ufmms_tb_if.sv
bench/union_find_min_max_size_tb.sv
